### design/rdts_pkg.sv
// ----------------------------------------------------------------------------
// rdts_pkg
// Shared widths, limits and register indexes of the depth-to-space scatter unit.
// ----------------------------------------------------------------------------
package rdts_pkg;

	localparam int MATRIX_W  = 8;
	localparam int IN_DIM_W  = 8;
	localparam int DEPTH_W   = 6;
	localparam int VALUE_W   = 32;
	localparam int OUT_DIM_W = 12;
	localparam int ADDR_W    = 24;

	localparam int LEVELS_W  = 3;
	localparam int STEP_W    = 5;
	localparam int BOUND_W   = 13;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam int DEF_MAX_IN_DIM  = 256;
	localparam int DEF_MAX_DEPTH   = 64;
	localparam int DEF_MAX_OUT_DIM = 4096;
	localparam int DEF_MAX_LEVELS  = 4;

	localparam int FIELD_LIMIT = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 3'd6;

endpackage

### design/recursive_depth_to_space_scatter_unit.sv
// ----------------------------------------------------------------------------
// recursive_depth_to_space_scatter_unit
// Maps stacked feature-map elements of one channel to output positions.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle unless in_stall is high. Its steps: decode
// and digit gathering, the step multiply, the offset add with bound check, and
// the row-pitch multiply for the linear address, each behind its own register.
// Items of other channels, outside the stack or outside the output bounds are
// dropped and leave a bubble. A stall on the output backs up only the stages
// that hold an item, so empty stages still accept. Configuration writes are
// taken in any cycle (cfg_ready is always high) and must be made while idle.
module recursive_depth_to_space_scatter_unit
	import rdts_pkg::*;
#(
	parameter int MAX_IN_DIM  = DEF_MAX_IN_DIM,
	parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
	parameter int MAX_OUT_DIM = DEF_MAX_OUT_DIM,
	parameter int MAX_LEVELS  = DEF_MAX_LEVELS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MATRIX_W-1:0]   matrix_index,
	input  logic [IN_DIM_W-1:0]   in_row,
	input  logic [IN_DIM_W-1:0]   in_col,
	input  logic [DEPTH_W-1:0]    in_depth,
	input  logic [VALUE_W-1:0]    elem_value,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_DIM_W-1:0]  out_row,
	output logic [OUT_DIM_W-1:0]  out_col,
	output logic [ADDR_W-1:0]     out_address,
	output logic [VALUE_W-1:0]    out_value
);

	localparam int IDX_W   = IN_DIM_W + (1 << LEVELS_W) - 1;
	localparam int BIT_IDX_W = $clog2(IDX_W);
	localparam int PROD_W  = IDX_W + STEP_W;
	localparam int POS_W   = PROD_W + 1;
	localparam int DIGITS  = MATRIX_W / 2;
	localparam int LIM_A   = (MAX_OUT_DIM < FIELD_LIMIT) ? MAX_OUT_DIM : FIELD_LIMIT;
	localparam int LVL_MAX = (MAX_LEVELS > 7) ? 7 : MAX_LEVELS;
	localparam int ADDR_FULL_W = OUT_DIM_W + BOUND_W + 1;

	logic [LEVELS_W-1:0]   levels_q;
	logic [DEPTH_W-1:0]    channel_q;
	logic [OUT_DIM_W-1:0]  row_offset_q;
	logic [OUT_DIM_W-1:0]  col_offset_q;
	logic [STEP_W-1:0]     base_step_q;
	logic [BOUND_W-1:0]    out_rows_q;
	logic [BOUND_W-1:0]    out_cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q     <= LEVELS_W'(1);
			channel_q    <= '0;
			row_offset_q <= '0;
			col_offset_q <= '0;
			base_step_q  <= STEP_W'(1);
			out_rows_q   <= BOUND_W'(FIELD_LIMIT);
			out_cols_q   <= BOUND_W'(FIELD_LIMIT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEVELS:     levels_q     <= cfg_data[LEVELS_W-1:0];
				REG_CHANNEL:    channel_q    <= cfg_data[DEPTH_W-1:0];
				REG_ROW_OFFSET: row_offset_q <= cfg_data[OUT_DIM_W-1:0];
				REG_COL_OFFSET: col_offset_q <= cfg_data[OUT_DIM_W-1:0];
				REG_BASE_STEP:  base_step_q  <= cfg_data[STEP_W-1:0];
				REG_OUT_ROWS:   out_rows_q   <= cfg_data[BOUND_W-1:0];
				REG_OUT_COLS:   out_cols_q   <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// effective levels and bounds
	logic [LEVELS_W-1:0] lv;
	logic [BOUND_W-1:0]  row_bound;
	logic [BOUND_W-1:0]  col_bound;

	always_comb begin
		if (levels_q == '0)
			lv = LEVELS_W'(1);
		else if (32'(levels_q) > 32'(LVL_MAX))
			lv = LEVELS_W'(LVL_MAX);
		else
			lv = levels_q;
		row_bound = (32'(out_rows_q) > 32'(LIM_A)) ? BOUND_W'(LIM_A) : out_rows_q;
		col_bound = (32'(out_cols_q) > 32'(LIM_A)) ? BOUND_W'(LIM_A) : out_cols_q;
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !vld_s4 || !out_stall;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: filter and gather digit bits
	logic [IDX_W-1:0]     row_bits;
	logic [IDX_W-1:0]     col_bits;
	logic [BIT_IDX_W-1:0] bit_idx;
	logic [IDX_W-1:0]     row_idx;
	logic [IDX_W-1:0]     col_idx;
	logic                 pass_in;

	always_comb begin
		row_bits = '0;
		col_bits = '0;
		bit_idx  = '0;
		for (int p = 0; p < DIGITS; p++) begin
			if (p < int'(lv)) begin
				bit_idx = BIT_IDX_W'(int'(lv) - 1 - p);
				row_bits[bit_idx] = matrix_index[2 * p + 1];
				col_bits[bit_idx] = matrix_index[2 * p];
			end
		end
		row_idx = (IDX_W'(in_row) << lv) | row_bits;
		col_idx = (IDX_W'(in_col) << lv) | col_bits;
		pass_in = (in_depth == channel_q)
			&& (32'(in_depth) < 32'(MAX_DEPTH))
			&& (32'(in_row) < 32'(MAX_IN_DIM))
			&& (32'(in_col) < 32'(MAX_IN_DIM))
			&& ((matrix_index >> {lv, 1'b0}) == '0);
	end

	logic [IDX_W-1:0]   row_idx_s1, col_idx_s1;
	logic [VALUE_W-1:0] value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (rdy_s1)
			vld_s1 <= in_valid && pass_in;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			row_idx_s1 <= row_idx;
			col_idx_s1 <= col_idx;
			value_s1   <= elem_value;
		end
	end

	// stage 2: scale by step
	logic [PROD_W-1:0]  row_prod_s2, col_prod_s2;
	logic [VALUE_W-1:0] value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (rdy_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			row_prod_s2 <= PROD_W'(base_step_q) * PROD_W'(row_idx_s1);
			col_prod_s2 <= PROD_W'(base_step_q) * PROD_W'(col_idx_s1);
			value_s2    <= value_s1;
		end
	end

	// stage 3: add offsets, check bounds
	logic [POS_W-1:0] row_pos, col_pos;
	logic             in_bounds;

	always_comb begin
		row_pos   = POS_W'(row_offset_q) + POS_W'(row_prod_s2);
		col_pos   = POS_W'(col_offset_q) + POS_W'(col_prod_s2);
		in_bounds = (row_pos < POS_W'(row_bound)) && (col_pos < POS_W'(col_bound));
	end

	logic [OUT_DIM_W-1:0] row_s3, col_s3;
	logic [VALUE_W-1:0]   value_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (rdy_s3)
			vld_s3 <= vld_s2 && in_bounds;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			row_s3   <= row_pos[OUT_DIM_W-1:0];
			col_s3   <= col_pos[OUT_DIM_W-1:0];
			value_s3 <= value_s2;
		end
	end

	// stage 4: linear address
	logic [ADDR_FULL_W-1:0] addr_full;

	assign addr_full = ADDR_FULL_W'(row_s3) * ADDR_FULL_W'(col_bound)
		+ ADDR_FULL_W'(col_s3);

	logic [OUT_DIM_W-1:0] row_s4, col_s4;
	logic [ADDR_W-1:0]    addr_s4;
	logic [VALUE_W-1:0]   value_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (rdy_s4)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			row_s4   <= row_s3;
			col_s4   <= col_s3;
			addr_s4  <= addr_full[ADDR_W-1:0];
			value_s4 <= value_s3;
		end
	end

	assign out_valid   = vld_s4;
	assign out_row     = row_s4;
	assign out_col     = col_s4;
	assign out_address = addr_s4;
	assign out_value   = value_s4;

endmodule

### sim/scatter_monitor.sv
// ----------------------------------------------------------------------------
// scatter_monitor
// Watches the register, element and write channels of the scatter unit.
// Keeps its own copy of the registers and works out where each accepted
// element must land. It compares every output write, field by field and in
// order, against the oldest write still expected.
// ----------------------------------------------------------------------------
module scatter_monitor
	import rdts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [MATRIX_W-1:0]   matrix_index,
	input  logic [IN_DIM_W-1:0]   in_row,
	input  logic [IN_DIM_W-1:0]   in_col,
	input  logic [DEPTH_W-1:0]    in_depth,
	input  logic [VALUE_W-1:0]    elem_value,

	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [OUT_DIM_W-1:0]  out_row,
	input  logic [OUT_DIM_W-1:0]  out_col,
	input  logic [ADDR_W-1:0]     out_address,
	input  logic [VALUE_W-1:0]    out_value,

	output int                    mismatch_count,
	output int                    writes_pending,
	output int                    elements_seen,
	output int                    writes_checked
);

	typedef struct packed {
		logic [OUT_DIM_W-1:0] row;
		logic [OUT_DIM_W-1:0] col;
		logic [ADDR_W-1:0]    addr;
		logic [VALUE_W-1:0]   value;
	} placement_t;

	logic [LEVELS_W-1:0]  cur_levels;
	logic [DEPTH_W-1:0]   cur_channel;
	logic [OUT_DIM_W-1:0] cur_row_off;
	logic [OUT_DIM_W-1:0] cur_col_off;
	logic [STEP_W-1:0]    cur_step;
	logic [BOUND_W-1:0]   cur_rows;
	logic [BOUND_W-1:0]   cur_cols;

	placement_t expected_writes[$];
	placement_t want;
	placement_t target;
	int         errs;

	function automatic bit scatter_target(
		input logic [MATRIX_W-1:0] midx,
		input logic [IN_DIM_W-1:0] r,
		input logic [IN_DIM_W-1:0] c,
		input logic [DEPTH_W-1:0]  d,
		input logic [VALUE_W-1:0]  v,
		output placement_t         p
	);
		int unsigned     lv;
		int unsigned     pos;
		logic [1:0]      digit;
		longint unsigned scale, wgt, row, col, rb, cb;
		lv = (cur_levels == 0) ? 1 : cur_levels;
		if (lv > DEF_MAX_LEVELS)
			lv = DEF_MAX_LEVELS;
		p = '0;
		if (d != cur_channel || d >= DEF_MAX_DEPTH)
			return 1'b0;
		if ((midx >> (2 * lv)) != 0)
			return 1'b0;
		scale = 64'(cur_step) << lv;
		row = 64'(cur_row_off) + 64'(r) * scale;
		col = 64'(cur_col_off) + 64'(c) * scale;
		for (int j = 0; j < lv; j++) begin
			pos = lv - 1 - j;
			digit = 2'((midx >> (2 * pos)) & 3);
			wgt = 64'(cur_step) << j;
			if (digit[1])
				row += wgt;
			if (digit[0])
				col += wgt;
		end
		rb = cur_rows;
		if (rb > DEF_MAX_OUT_DIM)
			rb = DEF_MAX_OUT_DIM;
		if (rb > FIELD_LIMIT)
			rb = FIELD_LIMIT;
		cb = cur_cols;
		if (cb > DEF_MAX_OUT_DIM)
			cb = DEF_MAX_OUT_DIM;
		if (cb > FIELD_LIMIT)
			cb = FIELD_LIMIT;
		if (row >= rb || col >= cb)
			return 1'b0;
		p.row = row[OUT_DIM_W-1:0];
		p.col = col[OUT_DIM_W-1:0];
		p.addr = ADDR_W'(row * cb + col);
		p.value = v;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_levels <= 3'd1;
			cur_channel <= '0;
			cur_row_off <= '0;
			cur_col_off <= '0;
			cur_step <= 5'd1;
			cur_rows <= 13'd4096;
			cur_cols <= 13'd4096;
			expected_writes.delete();
			mismatch_count <= 0;
			writes_pending <= 0;
			elements_seen <= 0;
			writes_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEVELS:     cur_levels <= cfg_data[LEVELS_W-1:0];
					REG_CHANNEL:    cur_channel <= cfg_data[DEPTH_W-1:0];
					REG_ROW_OFFSET: cur_row_off <= cfg_data[OUT_DIM_W-1:0];
					REG_COL_OFFSET: cur_col_off <= cfg_data[OUT_DIM_W-1:0];
					REG_BASE_STEP:  cur_step <= cfg_data[STEP_W-1:0];
					REG_OUT_ROWS:   cur_rows <= cfg_data[BOUND_W-1:0];
					REG_OUT_COLS:   cur_cols <= cfg_data[BOUND_W-1:0];
					default: ;
				endcase
			end
			errs = 0;
			if (out_valid && !out_stall) begin
				writes_checked <= writes_checked + 1;
				if (expected_writes.size() == 0) begin
					$display("%0t: unexpected write row %0d col %0d addr %0d value %h",
						$time, out_row, out_col, out_address, out_value);
					errs = 1;
				end else begin
					want = expected_writes.pop_front();
					if (out_row !== want.row) begin
						$display("%0t: out_row expected %0d, got %0d", $time, want.row, out_row);
						errs++;
					end
					if (out_col !== want.col) begin
						$display("%0t: out_col expected %0d, got %0d", $time, want.col, out_col);
						errs++;
					end
					if (out_address !== want.addr) begin
						$display("%0t: out_address expected %0d, got %0d",
							$time, want.addr, out_address);
						errs++;
					end
					if (out_value !== want.value) begin
						$display("%0t: out_value expected %h, got %h",
							$time, want.value, out_value);
						errs++;
					end
				end
			end
			mismatch_count <= mismatch_count + errs;
			if (in_valid && !in_stall) begin
				elements_seen <= elements_seen + 1;
				if (scatter_target(matrix_index, in_row, in_col, in_depth, elem_value, target))
					expected_writes.push_back(target);
			end
			writes_pending <= expected_writes.size();
		end
	end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the depth-to-space scatter unit.
// Programs a series of register settings, from the extremes to random ones,
// and sends directed and random elements under changing idle and stall
// patterns, including a long output hold-off. scatter_monitor does the checks.
// ----------------------------------------------------------------------------
module testbench;
	import rdts_pkg::*;

	localparam int LATENCY         = 4;
	localparam int DRAIN_CYCLES    = LATENCY + 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PHASE_ITEMS     = 76;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [MATRIX_W-1:0]   matrix_index = '0;
	logic [IN_DIM_W-1:0]   in_row = '0;
	logic [IN_DIM_W-1:0]   in_col = '0;
	logic [DEPTH_W-1:0]    in_depth = '0;
	logic [VALUE_W-1:0]    elem_value = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [OUT_DIM_W-1:0]  out_row;
	logic [OUT_DIM_W-1:0]  out_col;
	logic [ADDR_W-1:0]     out_address;
	logic [VALUE_W-1:0]    out_value;

	int mismatch_count;
	int writes_pending;
	int elements_seen;
	int writes_checked;

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_off_req = 1'b0;
	bit          hold_off_done = 1'b0;
	int          quiet_cycles = 0;
	int          settings_used = 1;

	int unsigned lv_eff = 1;
	int unsigned ch_cfg = 0;
	int unsigned roff_cfg = 0;
	int unsigned coff_cfg = 0;
	int unsigned step_cfg = 1;
	int unsigned rows_cfg = 4096;
	int unsigned cols_cfg = 4096;

	recursive_depth_to_space_scatter_unit i_dut (.*);

	scatter_monitor i_monitor (.*);

	always #2 clk = ~clk;

	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_unit(input int unsigned lv, input int unsigned ch,
			input int unsigned roff, input int unsigned coff, input int unsigned step,
			input int unsigned rows, input int unsigned cols);
		write_reg(REG_LEVELS, lv);
		write_reg(REG_CHANNEL, ch);
		write_reg(REG_ROW_OFFSET, roff);
		write_reg(REG_COL_OFFSET, coff);
		write_reg(REG_BASE_STEP, step);
		write_reg(REG_OUT_ROWS, rows);
		write_reg(REG_OUT_COLS, cols);
		cfg_valid <= 1'b0;
		lv_eff = (lv == 0) ? 1 : ((lv > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : lv);
		ch_cfg = ch;
		roff_cfg = roff;
		coff_cfg = coff;
		step_cfg = step;
		rows_cfg = rows;
		cols_cfg = cols;
		settings_used++;
	endtask

	task automatic send_element(input int unsigned midx, input int unsigned r,
			input int unsigned c, input int unsigned d, input logic [VALUE_W-1:0] v);
		while ($urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		matrix_index <= MATRIX_W'(midx);
		in_row <= IN_DIM_W'(r);
		in_col <= IN_DIM_W'(c);
		in_depth <= DEPTH_W'(d);
		elem_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_unit();
		in_valid <= 1'b0;
		@(posedge clk);
		while (writes_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// largest input row or column whose base position stays inside the bound
	function automatic int unsigned reach(input int unsigned offset, input int unsigned bound);
		int unsigned lim, scale, span;
		lim = (bound > FIELD_LIMIT) ? FIELD_LIMIT : bound;
		scale = step_cfg << lv_eff;
		if (scale == 0 || lim <= offset)
			return 255;
		span = (lim - offset - 1) / scale;
		return (span > 255) ? 255 : span;
	endfunction

	task automatic send_random_elements(input int n);
		int unsigned midx, r, c, d;
		for (int i = 0; i < n; i++) begin
			d = ($urandom_range(99, 0) < 85) ? ch_cfg : $urandom_range(63, 0);
			midx = ($urandom_range(99, 0) < 85) ?
				$urandom_range((1 << (2 * lv_eff)) - 1, 0) : $urandom_range(255, 0);
			r = ($urandom_range(99, 0) < 80) ?
				$urandom_range(reach(roff_cfg, rows_cfg), 0) : $urandom_range(255, 0);
			c = ($urandom_range(99, 0) < 80) ?
				$urandom_range(reach(coff_cfg, cols_cfg), 0) : $urandom_range(255, 0);
			send_element(midx, r, c, d, $urandom());
		end
	endtask

	function automatic int unsigned random_bound();
		case ($urandom_range(19, 0))
			0: return 0;
			1, 2: return $urandom_range(8191, 4097);
			3, 4, 5, 6: return $urandom_range(4096, 1);
			default: return 4096;
		endcase
	endfunction

	function automatic int unsigned random_offset();
		return ($urandom_range(99, 0) < 75) ? $urandom_range(255, 0) : $urandom_range(4095, 0);
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one level, channel zero, unit step, full bounds
		send_element(0, 0, 0, 0, 32'h0000_0000);
		send_element(3, 255, 255, 0, 32'hFFFF_FFFF);
		send_element(1, 128, 1, 0, 32'h8000_0001);
		send_element(2, 1, 128, 0, 32'h7FFF_FFFE);
		send_element(4, 0, 0, 0, 32'h1234_5678);
		send_element(255, 255, 255, 63, 32'hA5A5_A5A5);
		drain_unit();

		// deepest stack, step of 16, row offset at its top
		program_unit(4, 63, 4095, 0, 16, 4096, 4096);
		send_element(8'h00, 0, 0, 63, 32'h0000_FFFF);
		send_element(8'h55, 0, 15, 63, 32'hFFFF_0000);
		send_element(8'hAA, 0, 0, 63, 32'h5A5A_5A5A);
		send_element(8'hFF, 255, 255, 63, 32'hC3C3_C3C3);
		send_element(8'h00, 0, 0, 62, 32'h0F0F_0F0F);
		drain_unit();

		// zero levels and zero step; bounds above the field range
		program_unit(0, 42, 0, 0, 0, 8191, 8191);
		send_element(3, 255, 255, 42, 32'hDEAD_BEEF);
		send_element(0, 17, 33, 42, 32'hCAFE_F00D);
		send_element(4, 0, 0, 42, 32'h0BAD_CAFE);
		drain_unit();

		// levels above the maximum, zero row bound
		program_unit(7, 0, 4095, 4095, 31, 0, 4096);
		send_element(0, 0, 0, 0, 32'h1111_1111);
		send_element(255, 255, 255, 0, 32'h2222_2222);
		drain_unit();

		// zero column bound
		program_unit(2, 21, 7, 9, 5, 4096, 0);
		send_element(15, 3, 3, 21, 32'h3333_3333);
		drain_unit();

		// single output row, column offset at its top
		program_unit(2, 21, 0, 4095, 1, 1, 4096);
		send_element(0, 0, 0, 21, 32'h4444_4444);
		send_element(1, 0, 0, 21, 32'h5555_5555);
		send_element(2, 0, 0, 21, 32'h6666_6666);
		drain_unit();

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					gap_pct = 9;
					stall_pct = 83;
				end
				1: begin
					gap_pct = 83;
					stall_pct = 9;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int p = 0; p < 3; p++) begin
				program_unit(($urandom_range(99, 0) < 85) ?
						$urandom_range(4, 1) : $urandom_range(7, 0),
					$urandom_range(63, 0), random_offset(), random_offset(),
					($urandom_range(99, 0) < 85) ?
						$urandom_range(16, 1) : $urandom_range(31, 0),
					random_bound(), random_bound());
				if (mode == 2 && p == 0)
					hold_off_req = 1'b1;
				send_random_elements(PHASE_ITEMS);
				drain_unit();
			end
		end

		$display("Sent %0d elements through %0d register settings.", elements_seen,
			settings_used);
		$display("Compared %0d output writes under mixed idle, stall and hold-off patterns.",
			writes_checked);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
